// ===== sv/edrgb_pkg.sv =====
// Package: types, constants and per-channel quantizer for the RGB888 to RGB555 dither
package edrgb_pkg;

  // Field widths
  localparam int CHAN_W   = 8;
  localparam int PIX555_W = 15;
  localparam int Q5_W     = 5;
  localparam int RW_W     = 12;
  localparam int NUM_CH   = 3;

  // Config reset value and line store depth default
  localparam logic [RW_W-1:0] ROW_WIDTH_RST = RW_W'(640);
  localparam int MAX_WIDTH_DEF = 2048;

  // Dither arithmetic constants
  localparam int ROUND_SHIFT    = 4;
  localparam int ROUND_HALF     = 8;
  localparam int CLAMP_MAX      = 255;
  localparam int Q_ROUND        = 4;
  localparam logic [CHAN_W-1:0] Q_MASK = ~CHAN_W'(7);

  // Error widths: pixel error -4..7, pending sum -24..42, store sum -36..63
  localparam int ERR_W  = 4;
  localparam int PEND_W = 7;
  localparam int ESUM_W = 8;
  localparam int V_W    = 14;
  localparam int D_W    = 10;

  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic [PIX555_W-1:0]      pix555_t;
  typedef logic [Q5_W-1:0]          q5_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [PEND_W-1:0] pend_t;
  typedef logic signed [ESUM_W-1:0] esum_t;
  typedef esum_t [NUM_CH-1:0]       esum_vec_t;

  typedef struct packed {
    q5_t  q5;
    err_t err;
  } quant_t;

  // Add diffused error, round, clamp, quantize to 5 bits
  function automatic quant_t quantize(chan_t pix, err_t left, esum_t above);
    logic signed [V_W-1:0] v;
    logic signed [D_W-1:0] d_raw;
    logic [CHAN_W-1:0]     d;
    logic [CHAN_W:0]       q_raw;
    logic [CHAN_W-1:0]     q;
    logic signed [CHAN_W+1:0] diff;
    quant_t r;
    v = $signed({2'b00, pix, 4'b0000}) + V_W'(7) * V_W'(left) + V_W'(above);
    d_raw = D_W'((v + V_W'(ROUND_HALF)) >>> ROUND_SHIFT);
    if (d_raw < 0) begin
      d = '0;
    end else if (d_raw > D_W'(CLAMP_MAX)) begin
      d = CHAN_W'(CLAMP_MAX);
    end else begin
      d = d_raw[CHAN_W-1:0];
    end
    q_raw = {1'b0, d} + (CHAN_W+1)'(Q_ROUND);
    q = (q_raw > (CHAN_W+1)'(CLAMP_MAX)) ? CHAN_W'(CLAMP_MAX) : q_raw[CHAN_W-1:0];
    q = q & Q_MASK;
    diff = $signed({2'b00, d}) - $signed({2'b00, q});
    r.q5  = q[CHAN_W-1:CHAN_W-Q5_W];
    r.err = ERR_W'(diff);
    return r;
  endfunction

endpackage

// ===== sv/edrgb_if.sv =====
// Stream interfaces: RGB888 pixel input and RGB555 pixel output
interface edrgb_in_if import edrgb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t chan0;
  chan_t chan1;
  chan_t chan2;
  logic  frame_start;

  modport source (output valid, chan0, chan1, chan2, frame_start, input ready);
  modport sink   (input valid, chan0, chan1, chan2, frame_start, output ready);
endinterface

interface edrgb_out_if import edrgb_pkg::*; ();
  logic    valid;
  logic    ready;
  pix555_t pixel_555;

  modport source (output valid, pixel_555, input ready);
  modport sink   (input valid, pixel_555, output ready);
endinterface

// ===== sv/error_diffusion_rgb888_to_rgb555.sv =====
// Error-diffusion dither, RGB888 in, RGB555 out, with line store of next-row errors
// An input beat passes the pixel register, then the result register, to the output beat.
// Throughput: 1 pixel per cycle when not stalled; the line store has one write and one read port,
// row-end writes wait in a tail register until the port is free at the next row start.
// Reset clears control state and sets row_width to 640; the line store is not cleared,
// the first row of a frame never reads it.
module error_diffusion_rgb888_to_rgb555 import edrgb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  edrgb_in_if.sink        pix_in,
  edrgb_out_if.source     pix_out,
  input  logic            cfg_we_i,
  input  logic [RW_W-1:0] cfg_wdata_i
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW_MW = $clog2(MAX_WIDTH + 1);
  localparam int WW    = (RW_W > WW_MW) ? RW_W : WW_MW;

  // Config register
  logic [RW_W-1:0] row_width_q;
  logic [WW-1:0]   rw_ext, w_eff;

  // Column tracking at the input side
  logic [AW-1:0] col_q, col0, c0;
  logic          first_q, first0, last0;

  // Pixel stage
  logic          s1_valid_q, s1_first_q, s1_last_q, s1_fs_q;
  logic [AW-1:0] s1_col_q;
  chan_t [NUM_CH-1:0] s1_pix_q;
  logic          in_acc, s1_adv;

  // Row error state
  err_t  [NUM_CH-1:0] left_q, pend1_q;
  pend_t [NUM_CH-1:0] pend0_q;

  // Line store, tail register, bypass
  esum_vec_t     store_mem [MAX_WIDTH];
  esum_vec_t     rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  esum_vec_t     mem_wdata;
  logic          tail_valid_q;
  logic [AW-1:0] tail_addr_q;
  esum_vec_t     tail_data_q;
  logic          byp_valid_d, byp_valid_q;
  esum_vec_t     byp_data_d, byp_data_q;

  // Per-channel results
  quant_t    [NUM_CH-1:0] qres;
  esum_vec_t              sum_w, tail_new;
  pend_t     [NUM_CH-1:0] pend0_new;

  // Result register
  logic    out_valid_q;
  pix555_t out_pix_q;

  // Handshake
  assign s1_adv       = s1_valid_q && (!out_valid_q || pix_out.ready);
  assign pix_in.ready = !s1_valid_q || s1_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  // Effective width: zero acts as one, clamp to store depth
  always_comb begin
    rw_ext = WW'(row_width_q);
    if (rw_ext == '0) begin
      w_eff = WW'(1);
    end else if (rw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
  end

  // Column of the incoming beat
  always_comb begin
    col0   = pix_in.frame_start ? '0 : col_q;
    first0 = pix_in.frame_start | first_q;
    c0     = (WW'(col0) >= w_eff) ? AW'(w_eff - WW'(1)) : col0;
    last0  = (WW'(c0) + WW'(1)) >= w_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (in_acc) begin
      col_q   <= last0 ? '0 : c0 + AW'(1);
      first_q <= last0 ? 1'b0 : first0;
    end
  end

  // Pixel stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid_q <= pix_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= {pix_in.chan2, pix_in.chan1, pix_in.chan0};
      s1_col_q   <= c0;
      s1_first_q <= first0;
      s1_last_q  <= last0;
      s1_fs_q    <= pix_in.frame_start;
    end
  end

  // Dither per channel; row state reads as zero on a frame start
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      err_t  left_e, pend1_e;
      pend_t pend0_e;
      esum_t above;
      left_e  = s1_fs_q ? '0 : left_q[k];
      pend0_e = s1_fs_q ? '0 : pend0_q[k];
      pend1_e = s1_fs_q ? '0 : pend1_q[k];
      if (s1_first_q) begin
        above = '0;
      end else if (byp_valid_q) begin
        above = byp_data_q[k];
      end else begin
        above = rd_data_q[k];
      end
      qres[k]      = quantize(s1_pix_q[k], left_e, above);
      sum_w[k]     = esum_t'(pend0_e) + esum_t'(3) * esum_t'(qres[k].err);
      pend0_new[k] = pend_t'(pend1_e) + pend_t'(5) * pend_t'(qres[k].err);
      tail_new[k]  = esum_t'(pend0_new[k]);
    end
  end

  // Row state, cleared at the end of each row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      pend0_q <= '0;
      pend1_q <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < NUM_CH; k++) begin
        left_q[k]  <= s1_last_q ? '0 : qres[k].err;
        pend0_q[k] <= s1_last_q ? '0 : pend0_new[k];
        pend1_q[k] <= s1_last_q ? '0 : qres[k].err;
      end
    end
  end

  // Store write port: up-left entry first, else drain the tail
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_addr_q;
    mem_wdata = tail_data_q;
    if (s1_adv && (s1_col_q != '0)) begin
      mem_we    = 1'b1;
      mem_waddr = s1_col_q - AW'(1);
      mem_wdata = sum_w;
    end else if (tail_valid_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_q <= store_mem[c0];
    end
  end

  // Row-end entry waits here until the write port frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      tail_valid_q <= 1'b1;
    end else if (mem_we && !(s1_adv && (s1_col_q != '0))) begin
      tail_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      tail_addr_q <= s1_col_q;
      tail_data_q <= tail_new;
    end
  end

  // Forward entries that the memory read does not yet see
  always_comb begin
    byp_valid_d = 1'b0;
    byp_data_d  = tail_data_q;
    if (s1_adv && s1_last_q && (c0 == s1_col_q)) begin
      byp_valid_d = 1'b1;
      byp_data_d  = tail_new;
    end else if (s1_adv && (s1_col_q != '0) && (c0 == s1_col_q - AW'(1))) begin
      byp_valid_d = 1'b1;
      byp_data_d  = sum_w;
    end else if (tail_valid_q && (c0 == tail_addr_q)) begin
      byp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (in_acc) begin
      byp_valid_q <= byp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= byp_data_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q <= {qres[2].q5, qres[1].q5, qres[0].q5};
    end
  end

  assign pix_out.valid     = out_valid_q;
  assign pix_out.pixel_555 = out_pix_q;

  // A pending tail never competes with an up-left write
  a_tail_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_col_q != '0)) |-> !tail_valid_q)
    else $error("tail entry pending during a store write");

  // Column counter stays inside the store
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < WW'(MAX_WIDTH))
    else $error("column counter out of range");

  // Frame start restarts at column 0 on the first row
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pix_in.frame_start) |=> (s1_first_q && (s1_col_q == '0)))
    else $error("frame start did not reset position");

  // A result beat only appears from a pixel in the stage register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result beat without a pixel");

endmodule

// ===== sim/error_diffusion_rgb888_to_rgb555_test.sv =====
// Self-checking testbench for the RGB888 to RGB555 error-diffusion dither stream block
module error_diffusion_rgb888_to_rgb555_test;
  import edrgb_pkg::*;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    chan_t c2;
    logic  fs;
  } pixel_beat_t;

  typedef enum int {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic            clk_i;
  logic            rst_n;
  logic            cfg_we;
  logic [RW_W-1:0] cfg_wdata;

  edrgb_in_if  pix_in_bus ();
  edrgb_out_if pix_out_bus ();

  error_diffusion_rgb888_to_rgb555 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .pix_in      (pix_in_bus),
    .pix_out     (pix_out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Pending input beats and expected dithered pixels
  pixel_beat_t pixel_queue[$];
  pix555_t     dithered_queue[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int fail_count;
  int beats_sent;
  int beats_checked;
  int width_settings;

  // Stimulus-side view of the row width, used to open a new frame when it grows
  int  gen_eff_width;
  bit  force_frame;

  // Predictor state
  logic [RW_W-1:0] row_width_shadow;
  int dith_col;
  bit dith_first_row;
  int left_err[NUM_CH];
  int below_sum[2][NUM_CH];
  int line_err[MAX_WIDTH_DEF][NUM_CH];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_width(int w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  // Dither one pixel and advance the predictor state
  function automatic pix555_t dither_pixel(pixel_beat_t b);
    chan_t px[NUM_CH];
    q5_t   q5[NUM_CH];
    int    w, c, v, d, q, e, above;
    bit    row_end;
    px[0] = b.c0;
    px[1] = b.c1;
    px[2] = b.c2;
    if (b.fs) begin
      dith_col = 0;
      dith_first_row = 1'b1;
      left_err = '{default: 0};
      below_sum = '{default: '{default: 0}};
    end
    w = clamp_width(int'(row_width_shadow));
    c = dith_col;
    if (c >= w) c = w - 1;
    row_end = (c + 1 >= w);
    for (int k = 0; k < NUM_CH; k++) begin
      above = dith_first_row ? 0 : line_err[c][k];
      v = int'(px[k]) * 16 + 7 * left_err[k] + above;
      d = (v + ROUND_HALF) >>> ROUND_SHIFT;
      if (d < 0) d = 0;
      else if (d > CLAMP_MAX) d = CLAMP_MAX;
      q = d + Q_ROUND;
      if (q > CLAMP_MAX) q = CLAMP_MAX;
      q = q & ~7;
      e = d - q;
      q5[k] = q5_t'(q >> 3);
      // diffuse: right 7, down-left 3, down 5, down-right 1
      left_err[k] = e;
      if (c > 0) line_err[c-1][k] = below_sum[0][k] + 3 * e;
      below_sum[0][k] = below_sum[1][k] + 5 * e;
      below_sum[1][k] = e;
      if (row_end) line_err[c][k] = below_sum[0][k];
    end
    if (row_end) begin
      dith_col = 0;
      dith_first_row = 1'b0;
      left_err = '{default: 0};
      below_sum = '{default: '{default: 0}};
    end else begin
      dith_col = c + 1;
    end
    return {q5[2], q5[1], q5[0]};
  endfunction

  // Driver: one beat per free slot, gaps at random
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (pix_in_bus.valid && pix_in_bus.ready) begin
        dithered_queue.push_back(dither_pixel({pix_in_bus.chan0, pix_in_bus.chan1,
                                               pix_in_bus.chan2, pix_in_bus.frame_start}));
        beats_sent++;
      end
      if (!pix_in_bus.valid || pix_in_bus.ready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          pixel_beat_t b;
          b = pixel_queue.pop_front();
          pix_in_bus.valid       <= 1'b1;
          pix_in_bus.chan0       <= b.c0;
          pix_in_bus.chan1       <= b.c1;
          pix_in_bus.chan2       <= b.c2;
          pix_in_bus.frame_start <= b.fs;
        end else begin
          // idle: junk on the payload
          pix_in_bus.valid       <= 1'b0;
          pix_in_bus.chan0       <= chan_t'($urandom);
          pix_in_bus.chan1       <= chan_t'($urandom);
          pix_in_bus.chan2       <= chan_t'($urandom);
          pix_in_bus.frame_start <= 1'($urandom);
        end
      end
    end
  end

  // Monitor: check each output beat against the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (dithered_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected output beat 0x%04h", pix_out_bus.pixel_555);
        end else begin
          pix555_t exp_px;
          exp_px = dithered_queue.pop_front();
          if (pix_out_bus.pixel_555 !== exp_px) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: beat %0d pixel_555 expected 0x%04h got 0x%04h",
                       beats_checked, exp_px, pix_out_bus.pixel_555);
          end
        end
        beats_checked++;
      end
      pix_out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic set_idle(idle_mode_e mode);
    sender_idle_pct    = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 11 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 11 : 0;
  endtask

  task automatic push_pixel(int c0, int c1, int c2, bit fs);
    pixel_queue.push_back({chan_t'(c0), chan_t'(c1), chan_t'(c2), fs | force_frame});
    force_frame = 1'b0;
  endtask

  function automatic int rand_chan();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      2: return $urandom_range(7);
      3: return $urandom_range(255, 248);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Block is idle: every beat accepted and every result back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || pix_in_bus.valid || dithered_queue.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_row_width(int value);
    if (clamp_width(value) > gen_eff_width) force_frame = 1'b1;
    gen_eff_width = clamp_width(value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= RW_W'(value);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    row_width_shadow = RW_W'(value);
    width_settings++;
  endtask

  task automatic random_phase(int width, int n_items, idle_mode_e mode);
    write_row_width(width);
    set_idle(mode);
    for (int i = 0; i < n_items; i++)
      push_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(149) == 0);
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    pix_in_bus.valid       = 1'b0;
    pix_in_bus.chan0       = '0;
    pix_in_bus.chan1       = '0;
    pix_in_bus.chan2       = '0;
    pix_in_bus.frame_start = 1'b0;
    pix_out_bus.ready      = 1'b0;
    fail_count     = 0;
    beats_sent     = 0;
    beats_checked  = 0;
    width_settings = 1;
    force_frame    = 1'b0;
    gen_eff_width  = int'(ROW_WIDTH_RST);
    row_width_shadow = ROW_WIDTH_RST;
    dith_col       = 0;
    dith_first_row = 1'b1;
    left_err       = '{default: 0};
    below_sum      = '{default: '{default: 0}};
    set_idle(IDLE_OFF);
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset width, first row only
    for (int i = 0; i < 8; i++) push_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    wait_drained();

    // Directed: three-pixel rows, extremes, quantizer edges, mid-row frame start
    write_row_width(3);
    push_pixel(0, 0, 0, 1'b1);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(4, 3, 7, 1'b0);
    push_pixel(252, 251, 253, 1'b0);
    push_pixel(128, 127, 129, 1'b0);
    push_pixel(255, 0, 255, 1'b0);
    push_pixel(0, 255, 0, 1'b0);
    push_pixel(5, 6, 2, 1'b0);
    push_pixel(100, 150, 200, 1'b0);
    push_pixel(9, 250, 1, 1'b1);
    push_pixel(3, 3, 3, 1'b0);
    push_pixel(251, 251, 251, 1'b0);
    push_pixel(1, 254, 12, 1'b0);
    push_pixel(11, 11, 11, 1'b0);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(247, 8, 199, 1'b0);
    push_pixel(170, 85, 42, 1'b0);
    push_pixel(255, 255, 255, 1'b1);
    wait_drained();

    // Random: mixed widths, including 0, 1, 2048 and past the store depth
    random_phase(1,    120, IDLE_SENDER);
    random_phase(2,    150, IDLE_RECEIVER);
    random_phase(5,    200, IDLE_BOTH);
    random_phase(0,     80, IDLE_OFF);
    random_phase(17,   250, IDLE_SENDER);
    random_phase(4095,  60, IDLE_RECEIVER);
    random_phase(2048,  60, IDLE_BOTH);
    random_phase(7,    200, IDLE_OFF);
    random_phase(33,   250, IDLE_RECEIVER);
    random_phase(12,   200, IDLE_SENDER);
    random_phase(64,   180, IDLE_BOTH);
    random_phase(640,  100, IDLE_OFF);

    if (dithered_queue.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d expected pixels never arrived", dithered_queue.size());
    end
    $display("Covered %0d pixel beats (%0d checked) across %0d row-width settings,",
             beats_sent, beats_checked, width_settings);
    $display("with widths 0, 1, 2048 and 4095, frame starts mid-row and four idle patterns");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
